@@ hdl/icon_slot_table_macros.svh @@
// Assertion macros for the icon slot table.
`ifndef ICON_SLOT_TABLE_MACROS_SVH
`define ICON_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ISL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ISL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/isl_pkg.sv @@
// Shared types and constants of the icon slot table.
package isl_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned SLOT_W = 6;

  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [ID_W-1:0] EMPTY_ID = 16'hFFFF;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch the request, rewind the scan
    logic scan;    // issue one table read, advance the address
    logic finish;  // apply the update, load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;   // incoming request must search the table
    logic last_issue;  // current read address is the last slot
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage

@@ hdl/isl_if.sv @@
// Request and response channel interfaces of the icon slot table.
interface isl_req_if;
  logic                        valid;
  logic                        ready;
  logic [isl_pkg::OP_W-1:0]    opcode;
  logic [isl_pkg::ID_W-1:0]    icon_id;

  modport source (output valid, output opcode, output icon_id, input ready);
  modport sink (input valid, input opcode, input icon_id, output ready);
endinterface

interface isl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [isl_pkg::SLOT_W-1:0]  slot_number;
  logic                        hit;
  logic                        newly_allocated;
  logic                        table_full;

  modport source (output valid, output slot_number, output hit, output newly_allocated,
                  output table_full, input ready);
  modport sink (input valid, input slot_number, input hit, input newly_allocated,
                input table_full, output ready);
endinterface

@@ hdl/isl_ctrl.sv @@
// Controller state machine of the icon slot table.
module isl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  isl_pkg::sts_t  sts,
  output isl_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last read reach the compare stage
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/isl_dpath.sv @@
// Datapath of the icon slot table: slot memory, scan, compare and result register.
module isl_dpath #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  isl_pkg::cmd_t               cmd,
  output isl_pkg::sts_t               sts,
  input  logic [isl_pkg::OP_W-1:0]    in_opcode,
  input  logic [isl_pkg::ID_W-1:0]    in_icon_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [isl_pkg::SLOT_W-1:0]  out_slot_number,
  output logic                        out_hit,
  output logic                        out_newly_allocated,
  output logic                        out_table_full
);

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SW = (IW + 1 > isl_pkg::SLOT_W) ? IW + 1 : isl_pkg::SLOT_W;

  logic [isl_pkg::ID_W-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]    occ;

  logic [isl_pkg::OP_W-1:0] req_op;
  logic [isl_pkg::ID_W-1:0] req_id;
  logic                     req_act;

  logic [IW-1:0]            rd_addr;
  logic [isl_pkg::ID_W-1:0] rd_data;
  logic                     rd_occ;
  logic [IW-1:0]            cmp_idx;
  logic                     cmp_live;

  logic                     match_found;
  logic [IW-1:0]            match_idx;
  logic                     free_found;
  logic [IW-1:0]            free_idx;

  logic                     res_hit;
  logic                     res_alloc;
  logic                     res_full;
  logic                     res_release;
  logic [IW-1:0]            res_idx;
  logic [SW-1:0]            res_sum;

  assign sts.need_scan  = ((in_opcode == isl_pkg::OP_LOOKUP) ||
                           (in_opcode == isl_pkg::OP_RELEASE)) &&
                          (in_icon_id != isl_pkg::EMPTY_ID);
  assign sts.last_issue = (rd_addr == IW'(SLOT_COUNT - 1));
  assign sts.out_free   = !out_valid || out_ready;

  // Hold the request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op  <= in_opcode;
      req_id  <= in_icon_id;
      req_act <= sts.need_scan;
    end
  end

  // Read port and scan address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr <= '0;
    end else if (cmd.scan) begin
      rd_addr <= rd_addr + IW'(1);
    end
    if (cmd.scan) begin
      rd_data <= mem[rd_addr];
      rd_occ  <= occ[rd_addr];
      cmp_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= cmd.scan;
    end
  end

  // Compare stage: keep the lowest match and the lowest empty slot
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmp_live) begin
      if (!match_found && rd_occ && (rd_data == req_id)) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
      end
      if (!free_found && !rd_occ) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  assign res_hit     = req_act && match_found;
  assign res_alloc   = req_act && (req_op == isl_pkg::OP_LOOKUP) && !match_found && free_found;
  assign res_full    = req_act && (req_op == isl_pkg::OP_LOOKUP) && !match_found && !free_found;
  assign res_release = res_hit && (req_op == isl_pkg::OP_RELEASE);
  assign res_idx     = res_hit ? match_idx : free_idx;
  assign res_sum     = SW'(res_idx) + SW'(1);

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.finish && res_alloc) begin
      mem[free_idx] <= req_id;
    end
  end

  // Occupancy bits: set on allocation, cleared by release-one, all cleared at reset and by release-all
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.finish) begin
      if (req_op == isl_pkg::OP_CLEAR) begin
        occ <= '0;
      end else if (res_alloc) begin
        occ[free_idx] <= 1'b1;
      end else if (res_release) begin
        occ[match_idx] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_slot_number     <= (res_hit || res_alloc) ? res_sum[isl_pkg::SLOT_W-1:0] : '0;
      out_hit             <= res_hit;
      out_newly_allocated <= res_alloc;
      out_table_full      <= res_full;
    end
  end

endmodule

@@ hdl/icon_slot_table.sv @@
// Top level of the icon slot table: controller, datapath and checks.
//
// Usage
//   req carries one item per handshake: opcode (lookup/allocate, release one,
//   release all) and a 16-bit icon_id. rsp returns exactly one item per
//   request: slot_number (1-based, 0 for none), hit, newly_allocated and
//   table_full. Both channels move an item when valid and ready are high.
// Sequence
//   Lookup and release-one scan the slot memory one slot per cycle through
//   its single read port; a drain state lets the last read reach the compare
//   stage, then the finish step registers the result, and the next request
//   is taken only after that, so a new item waits until the last is finished.
//   Release-all and requests that do nothing skip the scan and go to finish.
// Reset
//   rst (synchronous) clears the occupancy bits, so every slot reads empty
//   at once; no clearing pass is needed.
// Stalls
//   A waiting result sits in the output register while the next request is
//   accepted and scanned; the finish step holds until rsp drains.
module icon_slot_table #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic   clk,
  input  logic   rst,
  isl_req_if.sink   req,
  isl_rsp_if.source rsp
);

`include "icon_slot_table_macros.svh"

  isl_pkg::cmd_t cmd;
  isl_pkg::sts_t sts;

  // Sequencer: idle, scan, drain the compare stage, finish
  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot memory, occupancy bits, compare stage and result register
  isl_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (req.opcode),
    .in_icon_id          (req.icon_id),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_slot_number     (rsp.slot_number),
    .out_hit             (rsp.hit),
    .out_newly_allocated (rsp.newly_allocated),
    .out_table_full      (rsp.table_full)
  );

  // At most one outcome flag per result item
  `ISL_ASSERT_NOW(a_flags_excl, rsp.valid,
    $onehot0({rsp.hit, rsp.newly_allocated, rsp.table_full}), "result flags overlap")
  // A full table reports no slot
  `ISL_ASSERT_NOW(a_full_no_slot, rsp.valid && rsp.table_full,
    rsp.slot_number == '0, "table_full with nonzero slot_number")
  // Found or claimed slots are never zero while numbers cannot wrap
  `ISL_ASSERT_NOW(a_slot_nonzero,
    (SLOT_COUNT < 64) && rsp.valid && (rsp.hit || rsp.newly_allocated),
    rsp.slot_number != '0, "hit or allocation with slot_number zero")
  // An accepted item keeps the block busy for the next cycle
  `ISL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready,
    !req.ready, "request taken while previous item in progress")

endmodule
